/* rtl/pfdc_pkg.sv */
// Package: shared types, field widths and constants of the person-follow drive controller.
`default_nettype none

package pfdc_pkg;

  localparam int unsigned BearingW = 13;
  localparam int unsigned DistW    = 12;
  localparam int unsigned GainW    = 16;
  localparam int unsigned AngW     = 14;
  localparam int unsigned LinW     = 12;
  localparam int unsigned SteerW   = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  typedef logic signed [BearingW-1:0] bearing_t;
  typedef logic        [DistW-1:0]    dist_t;
  typedef logic        [GainW-1:0]    gain_t;
  typedef logic signed [AngW-1:0]     ang_t;
  typedef logic        [LinW-1:0]     lin_t;
  typedef logic signed [SteerW-1:0]   steer_t;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_NEAR_GAIN   = 2'd0,
    REG_FAR_GAIN    = 2'd1,
    REG_SPEED_LIMIT = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_e;

  localparam gain_t NearGainRst   = 16'd2560;
  localparam gain_t FarGainRst    = 16'd3840;
  localparam lin_t  SpeedLimitRst = 12'd1200;

  localparam dist_t    NearDist     = 12'd120;
  localparam dist_t    DeadbandDist = 12'd90;
  localparam bearing_t DeadbandHi   = 13'sd80;
  localparam bearing_t DeadbandLo   = -13'sd80;
  localparam dist_t    SlowBandLow  = 12'd80;
  localparam dist_t    SlowBandHigh = 12'd150;
  localparam lin_t     SlowCap      = 12'd900;
  localparam ang_t     NearClamp    = 14'sd6400;
  localparam ang_t     FarClamp     = 14'sd8000;

endpackage : pfdc_pkg

`default_nettype wire

/* rtl/pfdc_in_if.sv */
// Interface: input beat channel (bearing sample with distance and mode flags).
`default_nettype none

interface pfdc_in_if import pfdc_pkg::*; ();
  logic     valid;
  logic     ready;
  bearing_t bearing;
  logic     no_target;
  dist_t    distance;
  logic     follow_mode;
  logic     danger_flag;
  logic     obstacle_ahead;
  logic     avoid_enable;

  modport source (
    output valid, bearing, no_target, distance, follow_mode, danger_flag,
           obstacle_ahead, avoid_enable,
    input  ready
  );

  modport sink (
    input  valid, bearing, no_target, distance, follow_mode, danger_flag,
           obstacle_ahead, avoid_enable,
    output ready
  );
endinterface : pfdc_in_if

`default_nettype wire

/* rtl/pfdc_out_if.sv */
// Interface: result beat channel (angular and linear drive pair).
`default_nettype none

interface pfdc_out_if import pfdc_pkg::*; ();
  logic valid;
  logic ready;
  ang_t angular_drive;
  lin_t linear_drive;
  logic obstacle_hold;

  modport source (
    output valid, angular_drive, linear_drive, obstacle_hold,
    input  ready
  );

  modport sink (
    input  valid, angular_drive, linear_drive, obstacle_hold,
    output ready
  );
endinterface : pfdc_out_if

`default_nettype wire

/* rtl/person_follow_drive_controller.sv */
// Top level: person-follow drive controller (steering and speed from a bearing sample).
// A beat passes from the input register to the result register once that one is free.
// Throughput: one beat per cycle while the receiver takes results; one multiply, round,
//   subtract and clamp sit between input and result register; steering term fed back.
// Beats that are not in follow mode or that flag danger produce no result beat.
// Reset (rst_ni low, async): pipeline empty, steering term 0, gains 2560 / 3840,
//   speed limit 1200.
`default_nettype none

module person_follow_drive_controller import pfdc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pfdc_in_if.sink                  in_i,
  pfdc_out_if.source               out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers (APB, zero wait state)
  // ---------------------------------------------------------------------------
  gain_t    near_gain_q, far_gain_q;
  lin_t     speed_limit_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_gain_q   <= NearGainRst;
      far_gain_q    <= FarGainRst;
      speed_limit_q <= SpeedLimitRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NEAR_GAIN:   near_gain_q   <= pwdata[GainW-1:0];
        REG_FAR_GAIN:    far_gain_q    <= pwdata[GainW-1:0];
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[LinW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NEAR_GAIN:   prdata = {{(ApbDataW-GainW){1'b0}}, near_gain_q};
      REG_FAR_GAIN:    prdata = {{(ApbDataW-GainW){1'b0}}, far_gain_q};
      REG_SPEED_LIMIT: prdata = {{(ApbDataW-LinW){1'b0}}, speed_limit_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances whenever the result register is free or
  // drained this cycle, so an item can enter every cycle.
  // ---------------------------------------------------------------------------
  logic     s1_valid_q;
  bearing_t s1_bearing_q;
  logic     s1_no_target_q;
  dist_t    s1_dist_q;
  logic     s1_follow_q, s1_danger_q, s1_obstacle_q, s1_avoid_q;

  logic out_valid_q;
  logic s1_adv;
  logic in_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_bearing_q   <= in_i.bearing;
      s1_no_target_q <= in_i.no_target;
      s1_dist_q      <= in_i.distance;
      s1_follow_q    <= in_i.follow_mode;
      s1_danger_q    <= in_i.danger_flag;
      s1_obstacle_q  <= in_i.obstacle_ahead;
      s1_avoid_q     <= in_i.avoid_enable;
    end
  end

  // ---------------------------------------------------------------------------
  // Drive computation
  // ---------------------------------------------------------------------------
  steer_t steer_q, steer_d;

  logic emits;        // item produces a result beat
  logic deadband;     // near and nearly straight ahead: no steering, no motion
  logic steer_upd;    // steering term is recomputed and stored
  logic is_near;

  assign emits    = s1_follow_q && !s1_danger_q;
  assign deadband = (s1_bearing_q > DeadbandLo) && (s1_bearing_q < DeadbandHi) &&
                    (s1_dist_q < DeadbandDist);
  assign is_near  = s1_dist_q < NearDist;
  assign steer_upd = emits && !s1_no_target_q && !deadband;

  // gain (unsigned Q8.8) * bearing, round half up to Q.4 by floor((p + 128) / 256)
  logic signed [GainW:0]                gain_s;
  logic signed [GainW+BearingW:0]       prod;
  logic signed [GainW+BearingW:0]       prod_r;
  logic signed [GainW+BearingW-8:0]     rnd;
  steer_t                               half_sum;
  logic signed [SteerW-2:0]             half;
  logic signed [SteerW+1:0]             diff;
  steer_t                               sat;

  assign gain_s = $signed({1'b0, (is_near ? near_gain_q : far_gain_q)});
  assign prod   = gain_s * s1_bearing_q;
  assign prod_r = prod + (GainW+BearingW+1)'(128);
  assign rnd    = prod_r[GainW+BearingW:8];

  // half of the old term, truncated toward zero
  assign half_sum = steer_q + steer_t'({{(SteerW-1){1'b0}}, steer_q[SteerW-1]});
  assign half     = half_sum[SteerW-1:1];

  assign diff = (SteerW+2)'(rnd) - (SteerW+2)'(half);

  // saturate to the 32-bit term
  always_comb begin
    if (diff[SteerW+1:SteerW-1] == 3'b000 || diff[SteerW+1:SteerW-1] == 3'b111) begin
      sat = diff[SteerW-1:0];
    end else if (diff[SteerW+1]) begin
      sat = {1'b1, {(SteerW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SteerW-1){1'b1}}};
    end
  end

  // command clamp: +-400 deg near, +-500 deg far
  logic signed [SteerW-1:0] lim_s;
  ang_t                     ang_clamped;

  assign lim_s = SteerW'(is_near ? NearClamp : FarClamp);

  always_comb begin
    if (sat > lim_s) begin
      ang_clamped = lim_s[AngW-1:0];
    end else if (sat < -lim_s) begin
      ang_clamped = ang_t'(-lim_s);
    end else begin
      ang_clamped = sat[AngW-1:0];
    end
  end

  // linear drive bands
  logic [DistW+2:0] lin_mid;   // 5 * d
  logic [DistW+3:0] lin_far;   // 10 * d
  lin_t             lin_band;

  assign lin_mid = {1'b0, s1_dist_q, 2'b00} + {3'b000, s1_dist_q};
  assign lin_far = {1'b0, s1_dist_q, 3'b000} + {3'b000, s1_dist_q, 1'b0};

  always_comb begin
    priority if (s1_dist_q > SlowBandHigh) begin
      lin_band = (lin_far > {4'b0000, speed_limit_q}) ? speed_limit_q : lin_far[LinW-1:0];
    end else if (s1_dist_q > SlowBandLow) begin
      lin_band = (lin_mid > {3'b000, SlowCap}) ? SlowCap : lin_mid[LinW-1:0];
    end else begin
      lin_band = '0;
    end
  end

  // result fields
  ang_t ang_d;
  lin_t lin_d;
  logic hold_d;

  always_comb begin
    ang_d  = '0;
    lin_d  = '0;
    hold_d = 1'b0;
    if (!s1_no_target_q) begin
      if (!deadband) begin
        ang_d = ang_clamped;
        lin_d = lin_band;
      end
      if (s1_obstacle_q && s1_avoid_q) begin
        lin_d  = '0;
        hold_d = 1'b1;
      end
    end
  end

  assign steer_d = (s1_adv && steer_upd) ? sat : steer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_q <= '0;
    end else begin
      steer_q <= steer_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  ang_t out_ang_q;
  lin_t out_lin_q;
  logic out_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= emits;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emits) begin
      out_ang_q  <= ang_d;
      out_lin_q  <= lin_d;
      out_hold_q <= hold_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.angular_drive = out_ang_q;
  assign out_o.linear_drive  = out_lin_q;
  assign out_o.obstacle_hold = out_hold_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_ang_q <= FarClamp) && (out_ang_q >= -FarClamp))
    else $error("angular drive beyond clamp");

  a_hold_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hold_q) |-> (out_lin_q == '0))
    else $error("obstacle hold with nonzero linear drive");

  a_steer_only_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_adv && steer_upd) |=> $stable(steer_q))
    else $error("steering term changed without a steering item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !s1_adv)
    else $error("result register overwritten while stalled");

endmodule : person_follow_drive_controller

`default_nettype wire

/* tb/tb_person_follow_drive_controller.sv */
// Testbench: randomized and directed check of the person-follow drive controller.
`timescale 1ns / 1ps

module tb_person_follow_drive_controller;
  import pfdc_pkg::*;

  localparam int          ClkHalf      = 5;
  localparam int          ResetCycles  = 12;
  localparam int          SettleCycles = 4;      // extra wait after the last expected result
  localparam int          LongHold     = 400;    // receiver hold-off, fills the pipe
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned DrivesPerPhase = 225;
  localparam int          NumPhases    = 6;

  // Control law thresholds, kept local so the package constants are checked too
  localparam int NearDistance  = 120;
  localparam int DeadbandDist  = 90;
  localparam int DeadbandQ4    = 80;
  localparam int NearLimitQ4   = 6400;
  localparam int FarLimitQ4    = 8000;
  localparam int CreepEdge     = 80;
  localparam int CruiseEdge    = 150;
  localparam int CreepCap      = 900;

  typedef struct packed {
    bearing_t bearing;
    logic     no_target;
    dist_t    distance;
    logic     follow_mode;
    logic     danger_flag;
    logic     obstacle_ahead;
    logic     avoid_enable;
  } bearing_beat_t;

  typedef struct packed {
    ang_t angular_drive;
    lin_t linear_drive;
    logic obstacle_hold;
  } drive_beat_t;

  // Predicts drive commands from accepted bearing beats and checks result beats.
  class drive_scoreboard;
    drive_beat_t drive_q[$];
    int unsigned mismatches;
    gain_t       near_gain;
    gain_t       far_gain;
    lin_t        speed_limit;
    int          steer_term;

    function new();
      near_gain   = 16'd2560;
      far_gain    = 16'd3840;
      speed_limit = 12'd1200;
      steer_term  = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] data);
      case (idx)
        REG_NEAR_GAIN:   near_gain   = data[15:0];
        REG_FAR_GAIN:    far_gain    = data[15:0];
        REG_SPEED_LIMIT: speed_limit = data[11:0];
        default: ;  // unmapped index: ignored
      endcase
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    function void mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t ns: %s", $time, msg);
    endfunction

    function void note_bearing(bearing_beat_t b);
      drive_beat_t d;
      longint      rate;
      longint      steer;
      longint      lim;
      longint      cmd;
      bit          near_tgt;
      int unsigned tgt_dist;
      if (!b.follow_mode || b.danger_flag) return;
      d        = '0;
      tgt_dist = b.distance;
      if (!b.no_target) begin
        if (!(int'(b.bearing) > -DeadbandQ4 && int'(b.bearing) < DeadbandQ4 &&
              tgt_dist < DeadbandDist)) begin
          near_tgt = tgt_dist < NearDistance;
          rate     = near_tgt ? longint'(near_gain) : longint'(far_gain);
          // round half up of the Q8.8 product, minus half the old term (toward zero)
          steer = ((rate * longint'(b.bearing) + 128) >>> 8) - longint'(steer_term / 2);
          if (steer > 64'sd2147483647)  steer = 64'sd2147483647;
          if (steer < -64'sd2147483648) steer = -64'sd2147483648;
          steer_term = int'(steer);
          lim = near_tgt ? NearLimitQ4 : FarLimitQ4;
          cmd = steer;
          if (cmd > lim)  cmd = lim;
          if (cmd < -lim) cmd = -lim;
          d.angular_drive = ang_t'(cmd);
          if (tgt_dist > CreepEdge && tgt_dist <= CruiseEdge)
            d.linear_drive = (5 * tgt_dist > CreepCap) ? lin_t'(CreepCap)
                                                       : lin_t'(5 * tgt_dist);
          else if (tgt_dist > CruiseEdge)
            d.linear_drive = (10 * tgt_dist > speed_limit) ? speed_limit
                                                           : lin_t'(10 * tgt_dist);
        end
        if (b.obstacle_ahead && b.avoid_enable) begin
          d.linear_drive  = '0;
          d.obstacle_hold = 1'b1;
        end
      end
      drive_q.push_back(d);
    endfunction

    function void check_drive(drive_beat_t got);
      drive_beat_t want;
      if (drive_q.size() == 0) begin
        mismatch($sformatf("unexpected beat ang=%0d lin=%0d hold=%0b",
                           got.angular_drive, got.linear_drive, got.obstacle_hold));
        return;
      end
      want = drive_q.pop_front();
      if (got.angular_drive !== want.angular_drive)
        mismatch($sformatf("angular_drive exp %0d got %0d",
                           want.angular_drive, got.angular_drive));
      if (got.linear_drive !== want.linear_drive)
        mismatch($sformatf("linear_drive exp %0d got %0d",
                           want.linear_drive, got.linear_drive));
      if (got.obstacle_hold !== want.obstacle_hold)
        mismatch($sformatf("obstacle_hold exp %0b got %0b",
                           want.obstacle_hold, got.obstacle_hold));
    endfunction

    function void flush();
      while (drive_q.size() != 0) begin
        void'(drive_q.pop_front());
        mismatch("expected beat never arrived");
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  pfdc_in_if  in_if ();
  pfdc_out_if out_if ();

  person_follow_drive_controller i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  drive_scoreboard scoreboard = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asked;
  int unsigned hold_seen;
  int          hold_left;
  int unsigned cycle_count;
  drive_beat_t seen_drive;
  bearing_beat_t seen_bearing;

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_asked) begin
      out_if.ready <= 1'b0;
      hold_left    <= LongHold;
      hold_seen    <= hold_asked;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: results are checked before the same edge's input beat is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        seen_drive.angular_drive = out_if.angular_drive;
        seen_drive.linear_drive  = out_if.linear_drive;
        seen_drive.obstacle_hold = out_if.obstacle_hold;
        scoreboard.check_drive(seen_drive);
      end
      if (in_if.valid && in_if.ready) begin
        seen_bearing.bearing        = in_if.bearing;
        seen_bearing.no_target      = in_if.no_target;
        seen_bearing.distance       = in_if.distance;
        seen_bearing.follow_mode    = in_if.follow_mode;
        seen_bearing.danger_flag    = in_if.danger_flag;
        seen_bearing.obstacle_ahead = in_if.obstacle_ahead;
        seen_bearing.avoid_enable   = in_if.avoid_enable;
        scoreboard.note_bearing(seen_bearing);
      end
    end
  end

  initial begin
    wait (cycle_count == CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bearing_beat_t mk_beat(int brg, bit nt, int tgt_dist, bit fm, bit dg,
                                            bit ob, bit av);
    bearing_beat_t b;
    b.bearing        = bearing_t'(brg);
    b.no_target      = nt;
    b.distance       = dist_t'(tgt_dist);
    b.follow_mode    = fm;
    b.danger_flag    = dg;
    b.obstacle_ahead = ob;
    b.avoid_enable   = av;
    return b;
  endfunction

  function automatic bearing_beat_t rand_beat();
    bearing_beat_t b;
    int            brg;
    int            tgt_dist;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: brg = int'($urandom_range(5760)) - 2880;
      6, 7:             brg = int'($urandom_range(200)) - 100;
      8:                brg = int'($urandom);
      default: begin
        case ($urandom_range(7))
          0: brg = -4096;
          1: brg = 4095;
          2: brg = -2880;
          3: brg = 2880;
          4: brg = -80;
          5: brg = 80;
          6: brg = 79;
          default: brg = -79;
        endcase
      end
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: tgt_dist = $urandom_range(200);
      4:          tgt_dist = $urandom_range(125, 75);
      5, 6, 7:    tgt_dist = $urandom_range(600);
      default:    tgt_dist = $urandom_range(4095);
    endcase
    b = mk_beat(brg, $urandom_range(99) < 8, tgt_dist, $urandom_range(99) < 92,
                $urandom_range(99) < 8, $urandom_range(99) < 30, $urandom_range(1));
    return b;
  endfunction

  // valid stays high across back-to-back beats; lowered only for a gap
  task automatic send_beat(bearing_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.bearing        <= b.bearing;
    in_if.no_target      <= b.no_target;
    in_if.distance       <= b.distance;
    in_if.follow_mode    <= b.follow_mode;
    in_if.danger_flag    <= b.danger_flag;
    in_if.obstacle_ahead <= b.obstacle_ahead;
    in_if.avoid_enable   <= b.avoid_enable;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    scoreboard.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n_drives, bit long_hold, bit mid_pause);
    bearing_beat_t b;
    int unsigned   given;
    bit            hold_done;
    bit            pause_done;
    given      = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (given < n_drives) begin
      if (long_hold && !hold_done && given >= n_drives / 4) begin
        hold_asked = hold_asked + 1;  // sender keeps offering meanwhile
        hold_done  = 1'b1;
      end
      if (mid_pause && !pause_done && given >= n_drives / 2) begin
        drain();
        pause_done = 1'b1;
      end
      b = rand_beat();
      send_beat(b);
      given++;
    end
    drain();
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.bearing        = '0;
    in_if.no_target      = 1'b0;
    in_if.distance       = '0;
    in_if.follow_mode    = 1'b0;
    in_if.danger_flag    = 1'b0;
    in_if.obstacle_ahead = 1'b0;
    in_if.avoid_enable   = 1'b0;
    out_if.ready         = 1'b0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    hold_asked           = 0;
    cycle_count          = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at reset gains
    send_beat(mk_beat(500, 0, 200, 0, 0, 0, 0));    // not following: no beat
    send_beat(mk_beat(500, 0, 200, 1, 1, 0, 0));    // danger: no beat
    send_beat(mk_beat(0, 1, 0, 1, 0, 1, 1));        // no target: stop, no hold
    send_beat(mk_beat(79, 0, 89, 1, 0, 0, 0));      // deadband
    send_beat(mk_beat(-79, 0, 0, 1, 0, 1, 1));      // deadband with obstacle hold
    send_beat(mk_beat(-80, 0, 50, 1, 0, 0, 0));     // just outside deadband bearing
    send_beat(mk_beat(80, 0, 89, 1, 0, 0, 0));
    send_beat(mk_beat(0, 0, 90, 1, 0, 0, 0));       // deadband distance edge
    send_beat(mk_beat(4095, 0, 0, 1, 0, 0, 0));     // near clamp, out-of-range bearing
    send_beat(mk_beat(-4096, 0, 4095, 1, 0, 0, 0)); // far clamp, speed limit
    send_beat(mk_beat(2880, 0, 119, 1, 0, 0, 0));
    send_beat(mk_beat(2880, 0, 120, 1, 0, 0, 0));   // gain switch
    send_beat(mk_beat(-2880, 0, 80, 1, 0, 0, 0));   // creep band edges
    send_beat(mk_beat(-2880, 0, 81, 1, 0, 0, 0));
    send_beat(mk_beat(100, 0, 150, 1, 0, 0, 0));
    send_beat(mk_beat(-100, 0, 151, 1, 0, 0, 0));
    send_beat(mk_beat(1000, 0, 200, 1, 0, 1, 0));   // obstacle, avoidance off
    send_beat(mk_beat(1000, 0, 200, 1, 0, 0, 1));
    send_beat(mk_beat(1000, 0, 200, 1, 0, 1, 1));   // obstacle hold
    send_beat(mk_beat(0, 1, 4095, 1, 1, 1, 1));     // no target under danger
    send_beat(mk_beat(-1, 0, 3000, 1, 0, 0, 0));
    send_beat(mk_beat(-1, 0, 0, 1, 0, 0, 0));
    send_beat(mk_beat(1, 0, 4095, 1, 0, 1, 1));
    drain();
    reg_write(REG_UNUSED, $urandom);  // unmapped: must not disturb anything

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0, 1: begin send_idle_pct = 19; recv_idle_pct = 58; end
        2, 3: begin send_idle_pct = 58; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: begin
          reg_write(REG_NEAR_GAIN, 32'd65535);
          reg_write(REG_FAR_GAIN, 32'd0);
          reg_write(REG_SPEED_LIMIT, 32'd0);
        end
        1: begin
          reg_write(REG_NEAR_GAIN, 32'd256);
          reg_write(REG_FAR_GAIN, 32'd512);
          reg_write(REG_SPEED_LIMIT, 32'd800);
        end
        3: begin
          reg_write(REG_NEAR_GAIN, 32'd0);
          reg_write(REG_FAR_GAIN, 32'd65535);
          reg_write(REG_SPEED_LIMIT, 32'd4095);
        end
        default: begin
          // upper bits random: only the register's width is kept
          reg_write(REG_NEAR_GAIN, $urandom);
          reg_write(REG_FAR_GAIN, $urandom);
          reg_write(REG_SPEED_LIMIT, $urandom);
        end
      endcase
      run_phase(DrivesPerPhase, p == 1, p == 3);
    end

    scoreboard.flush();
    if (scoreboard.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
